>>> rtl/core/pppm_pkg.sv
// Package for the pulse period power meter: item structs, operation and
// register codes, reset values and sizing constants. No dependencies.
`timescale 1ns / 1ps

package pppm_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int ENERGY_SCALE   = 1000000;

	localparam logic [31:0] PULSE_TIMEOUT_RST = 32'd2000000;
	localparam logic [31:0] POWER_MULT_RST    = 32'd12411000;
	localparam logic [31:0] CURRENT_MULT_RST  = 32'd1448440;
	localparam logic [31:0] VOLTAGE_MULT_RST  = 32'd490332;
	localparam logic        CUR_MODE_RST      = 1'b1;
	localparam logic        REARM_RST         = 1'b1;

	typedef enum logic [1:0] {
		OP_CF    = 2'd0,
		OP_CF1   = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_TIMEOUT   = 3'd0,
		REG_POWER     = 3'd1,
		REG_CURRENT   = 3'd2,
		REG_VOLTAGE   = 3'd3,
		REG_CUR_LEVEL = 3'd4,
		REG_REARM     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] timestamp_us;
	} in_item_t;

	typedef struct packed {
		logic        sel_level;
		logic [15:0] active_power;
		logic [15:0] current_centiamps;
		logic [15:0] voltage;
		logic [31:0] energy;
	} out_item_t;

endpackage

>>> rtl/core/pulse_period_power_meter_top.sv
// Pulse period power meter top level: edge timing state, read sequencer and
// a bit-serial multiply/divide unit. Depends on pppm_pkg.
`timescale 1ns / 1ps

// Usage:
// One item enters on in_item when in_valid is high and in_stall is low; each
// item gives exactly one result on out_item, held while out_stall is high.
// CF edge, CF1 edge and clear items need no sequencer: the result is
// registered at the accept edge and shows on the next cycle.
// A read item runs a restoring divider one quotient bit per cycle for power,
// current and voltage in turn (32 quotient bits each plus a finish step),
// with check states ST_CK1 and ST_CK2 between them; then the energy product
// by shift-and-add, and the energy divide by the constant scale over 64
// bits, whose end registers the read result. That serial unit sets the rate.
// No item is accepted while a read is in progress or while a result waits
// under a stall; a waiting result that is taken in the same cycle frees the
// input at once. The user must write configuration through the ports
// cfg_wr/cfg_idx/cfg_data only while idle; the block does not enforce it.
// Reset (arst_n low) restores register defaults and clears all edge times,
// periods and the edge count; the select level returns to its default.
module pulse_period_power_meter_top
	import pppm_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item
);

	localparam int TW = TIME_WIDTH;
	localparam int DW = (TW > 20) ? TW : 20;
	localparam int CW = (TW > 32) ? TW : 32;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_PW   = 8'b0000_0010,
		ST_CK1  = 8'b0000_0100,
		ST_CU   = 8'b0000_1000,
		ST_CK2  = 8'b0001_0000,
		ST_VO   = 8'b0010_0000,
		ST_MUL  = 8'b0100_0000,
		ST_EN   = 8'b1000_0000
	} state_t;

	state_t st_q;

	logic [31:0] timeout_q, pmult_q, cmult_q, vmult_q;
	logic        cur_lvl_q, rearm_q;

	logic [TW-1:0] last_cf_q, last_cf1_q, first_cf1_q, now_q;
	logic [TW-1:0] pper_q, cper_q, vper_q;
	logic [31:0]   edges_q;
	logic          sel_q;

	logic [63:0]   x_q;
	logic [DW-1:0] rem_q;
	logic [64:0]   prod_q;
	logic [6:0]    cnt_q;
	logic [15:0]   pw_q, cu_q, vo_q;

	out_item_t out_q;
	logic      out_vld_q;

	logic [TW-1:0] now_c;
	logic          in_acc;
	logic [DW-1:0] dvs;
	logic [DW:0]   trial;
	logic          qbit;
	logic [DW-1:0] rem_nx;
	logic [32:0]   psum;
	logic          cf1_to;
	logic          cf1_win;
	logic          out_set;
	logic [15:0]   q16;

	function automatic logic past_limit(logic [TW-1:0] now, logic [TW-1:0] then,
		logic [31:0] lim);
		logic [TW-1:0] d;
		d = now - then;
		return CW'(d) > CW'(lim);
	endfunction

	assign now_c     = TW'(in_item.timestamp_us);
	assign in_stall  = (st_q != ST_IDLE) || (out_vld_q && out_stall);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_vld_q;
	assign out_item  = out_q;
	assign cf1_win   = past_limit(now_c, first_cf1_q, timeout_q);
	assign out_set   = (st_q == ST_IDLE && in_acc && in_item.operation != OP_READ) ||
		(st_q == ST_EN && cnt_q == 7'd0);

	always_comb begin
		case (st_q)
			ST_PW:   dvs = DW'(pper_q);
			ST_CU:   dvs = DW'(cper_q);
			ST_VO:   dvs = DW'(vper_q);
			ST_EN:   dvs = DW'(ENERGY_SCALE);
			default: dvs = '0;
		endcase
	end

	assign trial  = {rem_q, x_q[63]};
	assign qbit   = trial >= {1'b0, dvs};
	assign rem_nx = qbit ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
	assign psum   = {1'b0, prod_q[63:32]} + (prod_q[0] ? {1'b0, pmult_q} : 33'd0);
	assign cf1_to = past_limit(now_q, last_cf1_q, timeout_q);
	assign q16    = (x_q[31:16] != 16'd0) ? 16'hFFFF : x_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= PULSE_TIMEOUT_RST;
			pmult_q     <= POWER_MULT_RST;
			cmult_q     <= CURRENT_MULT_RST;
			vmult_q     <= VOLTAGE_MULT_RST;
			cur_lvl_q   <= CUR_MODE_RST;
			rearm_q     <= REARM_RST;
			last_cf_q   <= '0;
			last_cf1_q  <= '0;
			first_cf1_q <= '0;
			now_q       <= '0;
			pper_q      <= '0;
			cper_q      <= '0;
			vper_q      <= '0;
			edges_q     <= '0;
			sel_q       <= CUR_MODE_RST;
			st_q        <= ST_IDLE;
			out_vld_q   <= 1'b0;
			out_q       <= '0;
			x_q         <= '0;
			rem_q       <= '0;
			prod_q      <= '0;
			pw_q        <= '0;
			cu_q        <= '0;
			vo_q        <= '0;
			cnt_q       <= '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					REG_TIMEOUT:   timeout_q <= cfg_data;
					REG_POWER:     pmult_q   <= cfg_data;
					REG_CURRENT:   cmult_q   <= cfg_data;
					REG_VOLTAGE:   vmult_q   <= cfg_data;
					REG_CUR_LEVEL: cur_lvl_q <= cfg_data[0];
					REG_REARM:     rearm_q   <= cfg_data[0];
					default:       ;
				endcase
			end

			out_vld_q <= out_set || (out_vld_q && out_stall);

			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						now_q <= now_c;
						case (in_item.operation)
							OP_CF: begin
								pper_q    <= now_c - last_cf_q;
								last_cf_q <= now_c;
								edges_q   <= edges_q + 32'd1;
								out_q     <= '{sel_level: sel_q, default: '0};
							end
							OP_CF1: begin
								last_cf1_q <= now_c;
								out_q      <= '{sel_level: sel_q ^ cf1_win, default: '0};
								if (cf1_win) begin
									if (sel_q == cur_lvl_q)
										cper_q <= (last_cf1_q == first_cf1_q) ?
											'0 : now_c - last_cf1_q;
									else
										vper_q <= (last_cf1_q == first_cf1_q) ?
											'0 : now_c - last_cf1_q;
									sel_q       <= ~sel_q;
									first_cf1_q <= now_c;
								end
							end
							OP_READ: begin
								if (past_limit(now_c, last_cf_q, timeout_q))
									pper_q <= '0;
								x_q   <= {pmult_q, 32'd0};
								rem_q <= '0;
								cnt_q <= 7'd32;
								st_q  <= ST_PW;
							end
							default: begin
								edges_q <= '0;
								out_q   <= '{sel_level: sel_q, default: '0};
							end
						endcase
					end
				end
				ST_PW, ST_CU, ST_VO, ST_EN: begin
					if (cnt_q != 7'd0) begin
						x_q   <= {x_q[62:0], qbit};
						rem_q <= rem_nx;
						cnt_q <= cnt_q - 7'd1;
					end else begin
						case (st_q)
							ST_PW: begin
								pw_q  <= (pper_q == '0) ? 16'd0 : q16;
								st_q  <= ST_CK1;
							end
							ST_CU: begin
								cu_q  <= (cper_q == '0) ? 16'd0 : q16;
								st_q  <= ST_CK2;
							end
							ST_VO: begin
								vo_q   <= (vper_q == '0) ? 16'd0 : q16;
								prod_q <= {33'd0, edges_q};
								cnt_q  <= 7'd32;
								st_q   <= ST_MUL;
							end
							default: begin
								out_q.sel_level         <= sel_q;
								out_q.active_power      <= pw_q;
								out_q.current_centiamps <= cu_q;
								out_q.voltage           <= vo_q;
								out_q.energy            <= (x_q[63:32] != 32'd0) ?
									32'hFFFF_FFFF : x_q[31:0];
								st_q      <= ST_IDLE;
							end
						endcase
					end
				end
				ST_CK1, ST_CK2: begin
					if (st_q == ST_CK1 && pw_q == 16'd0) begin
						cper_q <= '0;
					end else if (cf1_to) begin
						if (sel_q == cur_lvl_q)
							cper_q <= '0;
						else
							vper_q <= '0;
						sel_q <= ~sel_q;
						if (rearm_q) begin
							last_cf1_q  <= now_q;
							first_cf1_q <= now_q;
						end
					end
					x_q   <= {(st_q == ST_CK1) ? cmult_q : vmult_q, 32'd0};
					rem_q <= '0;
					cnt_q <= 7'd32;
					st_q  <= (st_q == ST_CK1) ? ST_CU : ST_VO;
				end
				ST_MUL: begin
					if (cnt_q != 7'd0) begin
						prod_q <= {1'b0, psum, prod_q[31:1]};
						cnt_q  <= cnt_q - 7'd1;
					end else begin
						x_q   <= prod_q[63:0];
						rem_q <= '0;
						cnt_q <= 7'd64;
						st_q  <= ST_EN;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule
